// ----- hw/rtl/inode_free_cache_allocator_macros.svh -----
// Assertion macros used by the inode allocator datapath.
// Needs signals named clk and rst_n in the including module.
`ifndef INODE_FREE_CACHE_ALLOCATOR_MACROS_SVH
`define INODE_FREE_CACHE_ALLOCATOR_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define IFCA_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ifca: assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define IFCA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ifca: assertion failed");

`endif

// ----- hw/rtl/ifca_pkg.sv -----
// Package for the inode allocator: sizes, codes, transaction structs,
// controller state type and the controller/datapath command and status groups.
// No dependencies.
package ifca_pkg;

    localparam int CACHE_DEPTH = 64;
    localparam int INODE_COUNT = 1024;

    localparam int ID_W   = 10;
    localparam int STAT_W = 2;
    localparam int MAP_AW = (INODE_COUNT > 1) ? $clog2(INODE_COUNT) : 1;
    localparam int POS_W  = $clog2(INODE_COUNT + 1);
    localparam int FC_W   = $clog2(INODE_COUNT + 1);
    localparam int CP_W   = $clog2(CACHE_DEPTH + 1);
    localparam int CA_W   = (CACHE_DEPTH > 1) ? $clog2(CACHE_DEPTH) : 1;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    localparam logic [STAT_W-1:0] STATUS_ALLOCATED = 2'd0;
    localparam logic [STAT_W-1:0] STATUS_NONE_FREE = 2'd1;
    localparam logic [STAT_W-1:0] STATUS_FREED     = 2'd2;

    typedef struct packed {
        logic            cmd;
        logic [ID_W-1:0] inode_id;
    } req_t;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [ID_W-1:0]   inode_id_res;
    } rsp_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_FREE,
        ST_POP,
        ST_SCAN_EVAL,
        ST_SCAN_CHK,
        ST_POP_RD
    } ctl_state_t;

    typedef struct packed {
        logic clear_step;
        logic idle_read;
        logic capture;
        logic scan_init;
        logic scan_read;
        logic scan_check;
        logic scan_wrap;
        logic scan_end;
        logic pop_read;
        logic pop_commit;
        logic free_commit;
        logic none_commit;
    } ctl_cmd_t;

    typedef struct packed {
        logic cache_empty;
        logic scan_more;
        logic scan_wrap_due;
        logic clear_last;
        logic out_busy;
    } dp_status_t;

endpackage

// ----- hw/rtl/inode_free_cache_allocator.sv -----
// Top level of the inode number allocator: free map plus stack cache.
// Instantiates ifca_ctrl and ifca_datapath; types from ifca_pkg.
//
//  channel | direction | transaction payload           | handshake
//  --------+-----------+-------------------------------+------------------
//  req     | in        | cmd, inode_id      (req_t)    | req_valid/req_stall
//  rsp     | out       | status, inode_id_res (rsp_t)  | rsp_valid/rsp_stall
//
// After reset a clearing pass walks the whole free map and sets it to all
// free; req_stall stays high throughout. One transaction at a time.
// A free, or an allocate that hits the cache, is accepted, then committed.
// A miss walks map entries from the rover, a read and a check for each, with
// one wrap to inode 0; it ends with a pop, or with none free if it finds nothing.
// A stalled result holds only the next commit; the next request is still taken.

module inode_free_cache_allocator (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_stall,
    input  ifca_pkg::req_t req,
    output logic           rsp_valid,
    input  logic           rsp_stall,
    output ifca_pkg::rsp_t rsp
);

    // Command group from controller to datapath, status group back
    ifca_pkg::ctl_cmd_t   cmd;
    ifca_pkg::dp_status_t status;

    // Sequence clearing pass, free, pop and refill scan
    ifca_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_cmd   (req.cmd),
        .req_stall (req_stall),
        .status    (status),
        .cmd       (cmd)
    );

    // Hold the free map, the cache and the result register
    ifca_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

endmodule

// ----- hw/rtl/ifca_datapath.sv -----
// Datapath of the inode allocator: free map, stack cache, pointers, scan
// counters and the result register. Depends on ifca_pkg and the macro header.
`include "inode_free_cache_allocator_macros.svh"

module ifca_datapath (
    input  logic                  clk,
    input  logic                  rst_n,
    input  ifca_pkg::ctl_cmd_t    cmd,
    output ifca_pkg::dp_status_t  status,
    input  ifca_pkg::req_t        req,
    output logic                  rsp_valid,
    input  logic                  rsp_stall,
    output ifca_pkg::rsp_t        rsp
);

    logic map_mem [ifca_pkg::INODE_COUNT];
    logic [ifca_pkg::MAP_AW-1:0] stack_mem [ifca_pkg::CACHE_DEPTH];

    logic                        map_rd_reg;
    logic [ifca_pkg::MAP_AW-1:0] stack_rd_reg;

    logic [ifca_pkg::CP_W-1:0]   pointer_reg, pointer_next;
    logic [ifca_pkg::FC_W-1:0]   free_count_reg, free_count_next;
    logic [ifca_pkg::MAP_AW-1:0] rover_reg, rover_next;
    logic [ifca_pkg::POS_W-1:0]  pos_reg, pos_next;
    logic [ifca_pkg::CP_W-1:0]   found_reg, found_next;
    logic                        wrap_reg, wrap_next;
    logic [ifca_pkg::MAP_AW-1:0] start_reg, start_next;
    logic [ifca_pkg::ID_W-1:0]   id_reg, id_next;
    logic                        out_valid_reg, out_valid_next;
    ifca_pkg::rsp_t              out_data_reg, out_data_next;

    logic                        map_we, map_wdata, map_re;
    logic [ifca_pkg::MAP_AW-1:0] map_waddr, map_raddr;
    logic                        stack_we, stack_re;
    logic [ifca_pkg::CA_W-1:0]   stack_waddr, stack_raddr;
    logic [ifca_pkg::MAP_AW-1:0] stack_wdata;

    logic cache_empty, id_ok, free_do, free_push, scan_push, out_load, out_busy;
    logic [ifca_pkg::MAP_AW-1:0] rover_start;

    assign cache_empty = (int'(pointer_reg) == ifca_pkg::CACHE_DEPTH);
    assign id_ok       = (int'(id_reg) < ifca_pkg::INODE_COUNT);
    assign free_do     = cmd.free_commit && id_ok && !map_rd_reg;
    assign free_push   = free_do && (pointer_reg != '0);
    assign scan_push   = cmd.scan_check && map_rd_reg;
    assign out_busy    = out_valid_reg && rsp_stall;
    assign out_load    = cmd.pop_commit || cmd.free_commit || cmd.none_commit;
    assign rover_start = (int'(rover_reg) < ifca_pkg::INODE_COUNT) ? rover_reg : '0;

    always_comb begin
        status.cache_empty   = cache_empty;
        status.scan_more     = (int'(found_reg) < ifca_pkg::CACHE_DEPTH)
                            && (int'(found_reg) < int'(free_count_reg))
                            && (wrap_reg ? (int'(pos_reg) < int'(start_reg))
                                         : (int'(pos_reg) < ifca_pkg::INODE_COUNT));
        status.scan_wrap_due = !wrap_reg && (int'(pos_reg) == ifca_pkg::INODE_COUNT);
        status.clear_last    = (int'(pos_reg) == ifca_pkg::INODE_COUNT - 1);
        status.out_busy      = out_busy;
    end

    // Free map ports
    always_comb begin
        map_we    = 1'b0;
        map_waddr = '0;
        map_wdata = 1'b0;
        if (cmd.clear_step) begin
            map_we    = 1'b1;
            map_waddr = ifca_pkg::MAP_AW'(pos_reg);
            map_wdata = 1'b1;
        end else if (cmd.pop_commit) begin
            map_we    = 1'b1;
            map_waddr = stack_rd_reg;
            map_wdata = 1'b0;
        end else if (free_do) begin
            map_we    = 1'b1;
            map_waddr = ifca_pkg::MAP_AW'(id_reg);
            map_wdata = 1'b1;
        end
    end

    assign map_re    = cmd.idle_read || cmd.scan_read;
    assign map_raddr = cmd.scan_read ? ifca_pkg::MAP_AW'(pos_reg)
                                     : ifca_pkg::MAP_AW'(req.inode_id);

    // Stack cache ports: push below the pointer, read at the pointer
    assign stack_we    = scan_push || free_push;
    assign stack_waddr = ifca_pkg::CA_W'(pointer_reg - 1'b1);
    assign stack_wdata = cmd.scan_check ? ifca_pkg::MAP_AW'(pos_reg)
                                        : ifca_pkg::MAP_AW'(id_reg);
    assign stack_re    = (cmd.idle_read && !cache_empty) || cmd.pop_read;
    assign stack_raddr = pointer_reg[ifca_pkg::CA_W-1:0];

    always_ff @(posedge clk) begin
        if (map_we) begin
            map_mem[map_waddr] <= map_wdata;
        end
        if (map_re) begin
            map_rd_reg <= map_mem[map_raddr];
        end
    end

    always_ff @(posedge clk) begin
        if (stack_we) begin
            stack_mem[stack_waddr] <= stack_wdata;
        end
        if (stack_re) begin
            stack_rd_reg <= stack_mem[stack_raddr];
        end
    end

    always_comb begin
        pointer_next    = pointer_reg;
        free_count_next = free_count_reg;
        rover_next      = rover_reg;
        pos_next        = pos_reg;
        found_next      = found_reg;
        wrap_next       = wrap_reg;
        start_next      = start_reg;
        id_next         = id_reg;

        if (cmd.capture) begin
            id_next = req.inode_id;
        end
        if (stack_we) begin
            pointer_next = pointer_reg - 1'b1;
        end else if (cmd.pop_commit) begin
            pointer_next = pointer_reg + 1'b1;
        end

        if (cmd.pop_commit && free_count_reg != '0) begin
            free_count_next = free_count_reg - 1'b1;
        end else if (free_do && int'(free_count_reg) != ifca_pkg::INODE_COUNT) begin
            free_count_next = free_count_reg + 1'b1;
        end

        if (cmd.scan_end) begin
            rover_next = (int'(pos_reg) >= ifca_pkg::INODE_COUNT)
                       ? '0 : ifca_pkg::MAP_AW'(pos_reg);
        end else if (free_do && pointer_reg == '0
                     && int'(id_reg) < int'(rover_reg)) begin
            rover_next = ifca_pkg::MAP_AW'(id_reg);
        end

        if (cmd.scan_init) begin
            start_next = rover_start;
            pos_next   = ifca_pkg::POS_W'(rover_start);
            found_next = '0;
            wrap_next  = 1'b0;
        end else if (cmd.scan_wrap) begin
            pos_next  = '0;
            wrap_next = 1'b1;
        end else if (cmd.clear_step || cmd.scan_check) begin
            pos_next = pos_reg + 1'b1;
        end
        if (scan_push) begin
            found_next = found_reg + 1'b1;
        end
    end

    // Result register: hold while stalled, drop once taken
    always_comb begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (out_load) begin
            out_valid_next = 1'b1;
            if (cmd.pop_commit) begin
                out_data_next.status       = ifca_pkg::STATUS_ALLOCATED;
                out_data_next.inode_id_res = ifca_pkg::ID_W'(stack_rd_reg);
            end else if (cmd.none_commit) begin
                out_data_next.status       = ifca_pkg::STATUS_NONE_FREE;
                out_data_next.inode_id_res = '0;
            end else begin
                out_data_next.status       = ifca_pkg::STATUS_FREED;
                out_data_next.inode_id_res = '0;
            end
        end else if (!rsp_stall) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            pointer_reg    <= ifca_pkg::CP_W'(ifca_pkg::CACHE_DEPTH);
            free_count_reg <= ifca_pkg::FC_W'(ifca_pkg::INODE_COUNT);
            rover_reg      <= '0;
            pos_reg        <= '0;
            found_reg      <= '0;
            wrap_reg       <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            pointer_reg    <= pointer_next;
            free_count_reg <= free_count_next;
            rover_reg      <= rover_next;
            pos_reg        <= pos_next;
            found_reg      <= found_next;
            wrap_reg       <= wrap_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk) begin
        start_reg    <= start_next;
        id_reg       <= id_next;
        out_data_reg <= out_data_next;
    end

    assign rsp_valid = out_valid_reg;
    assign rsp       = out_data_reg;

    `IFCA_ASSERT_SAME(a_load_when_free, out_load, !out_busy)
    `IFCA_ASSERT_SAME(a_pop_nonempty, cmd.pop_commit || cmd.pop_read, !cache_empty)
    `IFCA_ASSERT_SAME(a_scan_tracks_ptr, cmd.scan_check, int'(found_reg) + int'(pointer_reg) == ifca_pkg::CACHE_DEPTH)
    `IFCA_ASSERT_SAME(a_cache_le_free, 1'b1, int'(free_count_reg) + int'(pointer_reg) >= ifca_pkg::CACHE_DEPTH)

endmodule

// ----- hw/rtl/ifca_ctrl.sv -----
// Controller state machine of the inode allocator: sequences the clearing
// pass, free, pop and refill scan. Depends on ifca_pkg.

module ifca_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 req_valid,
    input  logic                 req_cmd,
    output logic                 req_stall,
    input  ifca_pkg::dp_status_t status,
    output ifca_pkg::ctl_cmd_t   cmd
);

    ifca_pkg::ctl_state_t state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ifca_pkg::ST_CLEAR: begin
                if (status.clear_last) begin
                    state_next = ifca_pkg::ST_IDLE;
                end
            end
            ifca_pkg::ST_IDLE: begin
                if (req_valid) begin
                    if (req_cmd == ifca_pkg::CMD_FREE) begin
                        state_next = ifca_pkg::ST_FREE;
                    end else if (status.cache_empty) begin
                        state_next = ifca_pkg::ST_SCAN_EVAL;
                    end else begin
                        state_next = ifca_pkg::ST_POP;
                    end
                end
            end
            ifca_pkg::ST_SCAN_EVAL: begin
                if (status.scan_more) begin
                    state_next = ifca_pkg::ST_SCAN_CHK;
                end else if (!status.scan_wrap_due) begin
                    state_next = ifca_pkg::ST_POP_RD;
                end
            end
            ifca_pkg::ST_SCAN_CHK: begin
                state_next = ifca_pkg::ST_SCAN_EVAL;
            end
            ifca_pkg::ST_POP_RD: begin
                if (!status.cache_empty) begin
                    state_next = ifca_pkg::ST_POP;
                end else if (!status.out_busy) begin
                    state_next = ifca_pkg::ST_IDLE;
                end
            end
            ifca_pkg::ST_POP, ifca_pkg::ST_FREE: begin
                if (!status.out_busy) begin
                    state_next = ifca_pkg::ST_IDLE;
                end
            end
            default: state_next = ifca_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        cmd       = '0;
        req_stall = 1'b1;
        unique case (state_reg)
            ifca_pkg::ST_CLEAR: begin
                cmd.clear_step = 1'b1;
            end
            ifca_pkg::ST_IDLE: begin
                req_stall     = 1'b0;
                cmd.idle_read = 1'b1;
                cmd.capture   = req_valid;
                cmd.scan_init = req_valid && req_cmd == ifca_pkg::CMD_ALLOC
                             && status.cache_empty;
            end
            ifca_pkg::ST_SCAN_EVAL: begin
                cmd.scan_read = status.scan_more;
                cmd.scan_wrap = !status.scan_more && status.scan_wrap_due;
                cmd.scan_end  = !status.scan_more && !status.scan_wrap_due;
            end
            ifca_pkg::ST_SCAN_CHK: begin
                cmd.scan_check = 1'b1;
            end
            ifca_pkg::ST_POP_RD: begin
                cmd.pop_read    = !status.cache_empty;
                cmd.none_commit = status.cache_empty && !status.out_busy;
            end
            ifca_pkg::ST_POP: begin
                cmd.pop_commit = !status.out_busy;
            end
            ifca_pkg::ST_FREE: begin
                cmd.free_commit = !status.out_busy;
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg <= ifca_pkg::ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule
